FILE: rtl/core/tccw_pkg.sv
// shared types and constants of the text console cursor writer
package tccw_pkg;

  // screen geometry defaults
  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  // field widths
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned ATTR_W  = 8;
  localparam int unsigned ADDR_W  = 11;
  localparam int unsigned CELL_W  = ATTR_W + CHAR_W;

  // result word: write, address, cell, clear, cursor
  localparam int unsigned OUT_RAW_W  = 1 + ADDR_W + CELL_W + 1 + ADDR_W;
  localparam int unsigned OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // character codes and register reset
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h00;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR      = 2'd0,
    KIND_BACKSPACE = 2'd1,
    KIND_CLEAR     = 2'd2
  } kind_t;

endpackage

FILE: rtl/core/text_console_cursor_writer.sv
// text console cursor writer: cursor tracking and cell write generation
//
// keeps the cursor row and column of a ROWS x COLUMNS text screen and turns each
// input word (a character, a backspace or a clear command, selected by in_tuser)
// into one result word: an optional attribute:character cell write, a request to
// blank the whole screen and the new cursor cell index. a printable character is
// written at the cursor and the cursor advances, wrapping at the end of a row;
// a newline goes to column 0 of the next row; stepping past the last row asks
// for a clear and homes the cursor. a backspace steps back (staying put at home)
// and writes a blank cell there. the attribute byte comes from the cfg port,
// which is always ready and should only be written while the block is idle.
// throughput is one word per cycle unless out_tready low holds a waiting result;
// each word passes an input register, then the result register. the cursor
// update is a loop around the cursor registers, so consecutive words need no
// stall. the output register lets a new word enter while a finished result waits.
module text_console_cursor_writer #(
  parameter int unsigned COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tccw_pkg::ATTR_W-1:0]     cfg_data,    // text_attribute
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tccw_pkg::CHAR_W-1:0]     in_tdata,    // char_code
  input  logic [tccw_pkg::KIND_W-1:0]     in_tuser,    // kind
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // cell_write [0], cell_address [11:1], cell_data [27:12],
  // clear_screen [28], cursor_position [39:29]
  output logic [tccw_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tccw_pkg::*;

  localparam int unsigned COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned IDX_W  = ROW_W + COL_W;
  localparam int unsigned WIDE_W = (IDX_W > ADDR_W) ? IDX_W : ADDR_W;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  // configuration
  logic [ATTR_W-1:0] attr_r;

  // input register
  logic              s1_valid_r;
  kind_t             kind_r;
  logic [CHAR_W-1:0] char_r;

  // cursor state
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;

  // result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  // result fields
  logic              wr;
  logic              clr;
  logic              row_step;
  logic [ADDR_W-1:0] cur_idx;
  logic [ADDR_W-1:0] new_idx;
  logic [ADDR_W-1:0] addr;
  logic [CELL_W-1:0] cell_val;

  logic adv;

  // row*COLUMNS+col, kept to the address width
  function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
    logic [WIDE_W-1:0] full;
    full = WIDE_W'(r) * WIDE_W'(COLUMNS) + WIDE_W'(c);
    return full[ADDR_W-1:0];
  endfunction

  // handshakes
  assign cfg_ready  = 1'b1;
  assign adv        = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // cursor step and cell write
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    wr       = 1'b0;
    clr      = 1'b0;
    row_step = 1'b0;
    cell_val = '0;
    unique case (kind_r)
      KIND_CHAR: begin
        if (char_r == CH_NEWLINE) begin
          col_nxt  = '0;
          row_step = 1'b1;
        end else begin
          wr       = 1'b1;
          cell_val = {attr_r, char_r};
          if (col_r == COL_LAST) begin
            col_nxt  = '0;
            row_step = 1'b1;
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
        end
        // moving below the last row blanks the screen and homes the cursor
        if (row_step) begin
          if (row_r == ROW_LAST) begin
            row_nxt = '0;
            col_nxt = '0;
            clr     = 1'b1;
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
        end
      end
      KIND_BACKSPACE: begin
        if (col_r != '0) begin
          col_nxt = col_r - COL_W'(1);
        end else if (row_r != '0) begin
          row_nxt = row_r - ROW_W'(1);
          col_nxt = COL_LAST;
        end
        wr       = 1'b1;
        cell_val = {attr_r, CH_BLANK};
      end
      KIND_CLEAR: begin
        row_nxt = '0;
        col_nxt = '0;
        clr     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign cur_idx = cell_index(row_r, col_r);
  assign new_idx = cell_index(row_nxt, col_nxt);

  // a character writes at the old cursor, a backspace at the new one
  always_comb begin
    if (!wr) begin
      addr = '0;
    end else if (kind_r == KIND_BACKSPACE) begin
      addr = new_idx;
    end else begin
      addr = cur_idx;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= ATTR_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        row_r       <= row_nxt;
        col_r       <= col_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready) begin
      kind_r <= kind_t'(in_tuser);
      char_r <= in_tdata;
    end
    if (adv) begin
      out_tdata_r <= OUT_DATA_W'({new_idx, clr, cell_val, addr, wr});
    end
  end

  // result cursor field follows the cursor registers
  a_cursor_matches: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_tdata_r[OUT_RAW_W-1 -: ADDR_W] == cur_idx))
    else $error("result cursor differs from cursor registers");

  // a clear command yields a clear request, no write and a homed cursor
  a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && kind_r == KIND_CLEAR) |=>
      (out_tdata_r[1 + ADDR_W + CELL_W] && !out_tdata_r[0] &&
       out_tdata_r[OUT_RAW_W-1 -: ADDR_W] == '0))
    else $error("clear command did not home the cursor");

  // any clear request leaves the cursor at home
  a_clear_at_home: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tdata_r[1 + ADDR_W + CELL_W]) |->
      (out_tdata_r[OUT_RAW_W-1 -: ADDR_W] == '0))
    else $error("clear request with cursor away from home");

  // an empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

endmodule
